[design/ccrlc_pkg.sv]
// Shared types, constants and round functions for the linear check core.
package ccrlc_pkg;

  localparam int WordBits    = 32;
  localparam int KeyWords    = 8;
  localparam int CfgIdxBits  = 3;
  localparam int OutCntBits  = 40;
  localparam int CountBitsDef = 40;
  // 5 full rounds as 10 half rounds, then one diagonal half a, one diagonal half b
  localparam int NumStages   = 12;
  localparam int StageBits   = 4;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;

  typedef struct packed {
    logic clear;
    logic pin;
    word_t pre6;
    word_t pre7;
  } side_t;

  function automatic word_t rotl(word_t v, int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] half_qr(word_t a, word_t b, word_t c, word_t d,
                                           logic second);
    word_t ta, tb, tc, td;
    ta = a + b;
    td = rotl(d ^ ta, second ? 8 : 16);
    tc = c + td;
    tb = rotl(b ^ tc, second ? 7 : 12);
    half_qr = {ta, tb, tc, td};
  endfunction

  function automatic logic approx(word_t x, word_t y, int p);
    approx = x[p] ^ y[p] ^ (x[p-1] & y[p-1]) ^ (x[p-1] & x[p-2] & y[p-2])
           ^ (y[p-1] & x[p-2] & y[p-2]);
  endfunction

endpackage

[design/ccrlc_cell.sv]
// One half-round cell of the round chain: column or diagonal, first or second half.
module ccrlc_cell import ccrlc_pkg::*; #(
  parameter int Stage = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   adv,
  input  logic   vld_in,
  input  state_t st_in,
  input  side_t  sd_in,
  output logic   vld_out,
  output state_t st_out,
  output side_t  sd_out
);

  localparam logic Diag   = ((Stage / 2) % 2) == 1;
  localparam logic Second = (Stage % 2) == 1;

  logic   vld_r;
  state_t st_r, st_nxt;
  side_t  sd_r, sd_nxt;

  always_comb begin
    st_nxt = st_in;
    sd_nxt = sd_in;
    for (int q = 0; q < 4; q++) begin
      int ia, ib, ic, id;
      logic [127:0] r;
      ia = q;
      ib = Diag ? 4 + ((q + 1) % 4) : 4 + q;
      ic = Diag ? 8 + ((q + 2) % 4) : 8 + q;
      id = Diag ? 12 + ((q + 3) % 4) : 12 + q;
      r = half_qr(st_in[ia], st_in[ib], st_in[ic], st_in[id], Second);
      st_nxt[ia] = r[127:96];
      st_nxt[ib] = r[95:64];
      st_nxt[ic] = r[63:32];
      st_nxt[id] = r[31:0];
    end
    if (Stage == NumStages - 2) begin
      sd_nxt.pin  = st_nxt[1][7] ^ st_nxt[11][12] ^ st_nxt[2][8] ^ st_nxt[9][26];
      sd_nxt.pre6 = st_nxt[6];
      sd_nxt.pre7 = st_nxt[7];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
    if (adv) begin
      st_r <= st_nxt;
      sd_r <= sd_nxt;
    end
  end

  assign vld_out = vld_r;
  assign st_out  = st_r;
  assign sd_out  = sd_r;

endmodule

[design/chacha_reduced_round_linear_check_core.sv]
// Top level of the reduced-round ChaCha linear-approximation check core.
// Usage:
//   Write key words 0..7 on the cfg port (index = word) while the core is idle.
//   Present IV words and clear_count on the in_ channel; an item is taken when
//   in_valid is high and in_stall is low.
//   The item passes a chain of 12 half-round cells, each a register stage, then a
//   parity and counter stage; out_ carries parity_match and match_count.
//   Throughput: one item per cycle while no output stall holds the chain; the whole chain moves as one.
//   When out_stall holds a valid result, the chain freezes and in_stall
//   rises so no item is lost; when the output is empty or taken, the chain
//   advances every cycle.
//   Reset clears the key words, valid bits and the match counter.
//   The counter saturates at 2^COUNT_BITS-1; match_count clamps at 2^40-1.
module chacha_reduced_round_linear_check_core import ccrlc_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [WordBits-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [31:0]           in_iv_word_0,
  input  logic [31:0]           in_iv_word_1,
  input  logic [31:0]           in_iv_word_2,
  input  logic [31:0]           in_iv_word_3,
  input  logic                  in_clear_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_parity_match,
  output logic [OutCntBits-1:0] out_match_count
);

  word_t [KeyWords-1:0] key_r;
  logic   [NumStages:0] vld;
  state_t [NumStages:0] st;
  side_t  [NumStages:0] sd;
  logic adv;

  logic                  out_valid_r;
  logic                  match_r;
  logic [OutCntBits-1:0] cnt_out_r;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_base;
  logic                  pout, match;

  localparam logic [COUNT_BITS-1:0] CntMax = '1;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r[cfg_index] <= cfg_data;
    end
  end

  assign st[0] = {in_iv_word_3, in_iv_word_2, in_iv_word_1, in_iv_word_0,
                  key_r[7], key_r[6], key_r[5], key_r[4],
                  key_r[3], key_r[2], key_r[1], key_r[0],
                  Sigma3, Sigma2, Sigma1, Sigma0};
  assign sd[0] = '{clear: in_clear_count, pin: 1'b0, pre6: '0, pre7: '0};
  assign vld[0] = in_valid;

  for (genvar g = 0; g < NumStages; g++) begin : g_cell
    ccrlc_cell #(.Stage(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_in(vld[g]), .st_in(st[g]), .sd_in(sd[g]),
      .vld_out(vld[g+1]), .st_out(st[g+1]), .sd_out(sd[g+1])
    );
  end

  always_comb begin
    pout = approx(st[NumStages][1], word_t'(0) - sd[NumStages].pre6, 7)
         ^ approx(st[NumStages][11], word_t'(0) - st[NumStages][12], 12)
         ^ approx(st[NumStages][2], word_t'(0) - sd[NumStages].pre7, 8)
         ^ approx(st[NumStages][9], word_t'(0) - st[NumStages][14], 26);
    match    = (sd[NumStages].pin == pout);
    cnt_base = sd[NumStages].clear ? '0 : cnt_r;
    cnt_nxt  = (match && cnt_base != CntMax) ? cnt_base + 1'b1 : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else if (adv) begin
      out_valid_r <= vld[NumStages];
      if (vld[NumStages]) begin
        cnt_r <= cnt_nxt;
      end
    end
    if (adv && vld[NumStages]) begin
      match_r <= match;
      if (cnt_nxt > COUNT_BITS'({OutCntBits{1'b1}})) begin
        cnt_out_r <= '1;
      end else begin
        cnt_out_r <= OutCntBits'(cnt_nxt);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_parity_match = match_r;
  assign out_match_count  = cnt_out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_count))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_parity_match |=>
      !out_valid || out_match_count <= $past(out_match_count) + 1)
    else $error("counter jumped");

endmodule

[tb/sv/ccrlc_checker.sv]
// Checker for the linear check core: predicts results and compares them.
`timescale 1ns / 1ps
module ccrlc_checker import ccrlc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [WordBits-1:0]   cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [31:0]           in_iv_word_0,
  input  logic [31:0]           in_iv_word_1,
  input  logic [31:0]           in_iv_word_2,
  input  logic [31:0]           in_iv_word_3,
  input  logic                  in_clear_count,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_parity_match,
  input  logic [OutCntBits-1:0] out_match_count,
  output int                    fail_count,
  output int                    pending
);

  typedef logic [15:0][31:0] chstate_t;

  typedef struct packed {
    logic                  parity_match;
    logic [OutCntBits-1:0] match_count;
  } verdict_t;

  logic [31:0]           key_copy [KeyWords];
  logic [OutCntBits-1:0] match_tally;
  verdict_t              expected_verdicts [$];

  function automatic logic [31:0] rot_left(logic [31:0] v, int n);
    logic [63:0] w;
    w = {v, v} << n;
    return w[63:32];
  endfunction

  function automatic chstate_t half_step(chstate_t s, int a, int b, int c, int d,
                                         bit second);
    s[a] = s[a] + s[b];
    s[d] = rot_left(s[d] ^ s[a], second ? 8 : 16);
    s[c] = s[c] + s[d];
    s[b] = rot_left(s[b] ^ s[c], second ? 7 : 12);
    return s;
  endfunction

  function automatic chstate_t diag_half(chstate_t s, bit second);
    s = half_step(s, 0, 5, 10, 15, second);
    s = half_step(s, 1, 6, 11, 12, second);
    s = half_step(s, 2, 7, 8, 13, second);
    s = half_step(s, 3, 4, 9, 14, second);
    return s;
  endfunction

  function automatic chstate_t column_pass(chstate_t s);
    for (int h = 0; h < 2; h++) begin
      s = half_step(s, 0, 4, 8, 12, h);
      s = half_step(s, 1, 5, 9, 13, h);
      s = half_step(s, 2, 6, 10, 14, h);
      s = half_step(s, 3, 7, 11, 15, h);
    end
    return s;
  endfunction

  function automatic logic carry_bit(logic [31:0] x, logic [31:0] y, int p);
    return x[p] ^ y[p] ^ (x[p-1] & y[p-1]) ^ (x[p-1] & x[p-2] & y[p-2])
         ^ (y[p-1] & x[p-2] & y[p-2]);
  endfunction

  function automatic logic parity_agrees(logic [31:0] iv0, logic [31:0] iv1,
                                         logic [31:0] iv2, logic [31:0] iv3);
    chstate_t    s;
    logic        pin, pout;
    logic [31:0] pre6, pre7;
    s[0] = 32'h61707865;
    s[1] = 32'h3320646e;
    s[2] = 32'h79622d32;
    s[3] = 32'h6b206574;
    for (int i = 0; i < 8; i++) s[4 + i] = key_copy[i];
    s[12] = iv0;
    s[13] = iv1;
    s[14] = iv2;
    s[15] = iv3;
    s = column_pass(s);
    s = diag_half(s, 0);
    s = diag_half(s, 1);
    s = column_pass(s);
    s = diag_half(s, 0);
    s = diag_half(s, 1);
    s = column_pass(s);
    s = diag_half(s, 0);
    pin  = s[1][7] ^ s[11][12] ^ s[2][8] ^ s[9][26];
    pre6 = s[6];
    pre7 = s[7];
    s = diag_half(s, 1);
    pout = carry_bit(s[1], 32'(0 - pre6), 7) ^ carry_bit(s[11], 32'(0 - s[12]), 12)
         ^ carry_bit(s[2], 32'(0 - pre7), 8) ^ carry_bit(s[9], 32'(0 - s[14]), 26);
    return pin == pout;
  endfunction

  assign pending = expected_verdicts.size();

  always @(posedge clk) begin
    verdict_t v;
    if (!rst_n) begin
      for (int i = 0; i < KeyWords; i++) key_copy[i] = '0;
      match_tally = '0;
      fail_count  = 0;
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: unexpected item match=%0d count=%0d",
                     out_parity_match, out_match_count);
        end else begin
          v = expected_verdicts.pop_front();
          if (v.parity_match !== out_parity_match || v.match_count !== out_match_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected match=%0d count=%0d, got match=%0d count=%0d",
                       v.parity_match, v.match_count, out_parity_match, out_match_count);
          end
        end
      end
      if (in_valid && !in_stall) begin
        v.parity_match = parity_agrees(in_iv_word_0, in_iv_word_1, in_iv_word_2,
                                       in_iv_word_3);
        if (in_clear_count) match_tally = '0;
        if (v.parity_match && match_tally != '1) match_tally = match_tally + 1'b1;
        v.match_count = match_tally;
        expected_verdicts.push_back(v);
      end
      if (cfg_we) key_copy[cfg_index] = cfg_data;
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the testbench: clock, reset, stimulus, key setup and verdict.
`timescale 1ns / 1ps
module testbench;
  import ccrlc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [WordBits-1:0]   cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [31:0]           in_iv_word_0 = '0;
  logic [31:0]           in_iv_word_1 = '0;
  logic [31:0]           in_iv_word_2 = '0;
  logic [31:0]           in_iv_word_3 = '0;
  logic                  in_clear_count = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_parity_match;
  logic [OutCntBits-1:0] out_match_count;
  int                    fail_count;
  int                    pending;
  int                    send_gap_pct = 0;
  int                    recv_stall_pct = 0;
  int                    quiet_cycles = 0;

  always #5 clk = ~clk;

  chacha_reduced_round_linear_check_core i_dut (.*);

  ccrlc_checker i_checker (.*);

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_item(logic [31:0] w0, logic [31:0] w1, logic [31:0] w2,
                           logic [31:0] w3, logic clr);
    int gap;
    gap = ($urandom_range(99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_iv_word_0   <= w0;
    in_iv_word_1   <= w1;
    in_iv_word_2   <= w2;
    in_iv_word_3   <= w3;
    in_clear_count <= clr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(int style);
    logic [31:0] w;
    for (int i = 0; i < KeyWords; i++) begin
      case (style)
        0: w = '0;
        1: w = '1;
        2: w = (i % 2) ? 32'h80000000 : 32'h55555555;
        default: w = $urandom;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= i[CfgIdxBits-1:0];
      cfg_data  <= w;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_items(int n);
    for (int k = 0; k < n; k++)
      send_item($urandom, $urandom, $urandom, $urandom, $urandom_range(99) < 4);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item('0, '0, '0, '0, 1'b0);
    send_item('1, '1, '1, '1, 1'b0);
    send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
    send_item(32'h00000001, 32'h7fffffff, 32'hffffffff, 32'h80000000, 1'b1);
    send_item(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b0);
    send_item('1, '1, '1, '1, 1'b1);
    drain();
    load_key(1);
    send_item('0, '0, '0, '0, 1'b1);
    send_item('1, '1, '1, '1, 1'b0);
    send_item(32'h80000000, 32'h0, 32'h80000000, 32'h0, 1'b0);
    drain();
    load_key(2);
    send_item('0, '1, '0, '1, 1'b0);
    send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1);
    drain();

    load_key(3);
    send_gap_pct   = 25;
    recv_stall_pct = 80;
    random_items(650);
    drain();
    load_key(0);
    send_gap_pct   = 80;
    recv_stall_pct = 25;
    random_items(300);
    drain();
    load_key(3);
    random_items(350);
    drain();
    load_key(1);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    random_items(650);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/ccrlc_pkg.sv
design/ccrlc_cell.sv
design/chacha_reduced_round_linear_check_core.sv
tb/sv/ccrlc_checker.sv
tb/sv/testbench.sv
